[rtl/mbwf_pkg.sv]
package mbwf_pkg;

	// Field widths of one polled sample and of one wheel command.
	localparam int RANGE_W   = 16;
	localparam int BEARING_W = 15;
	localparam int ID_W      = 16;
	localparam int SPEED_W   = 11;
	localparam int STATUS_W  = 2;

	// Bits of one stored sample inside a queued round.
	localparam int SAMPLE_BITS = RANGE_W + BEARING_W + ID_W;

	// Round outcome codes.
	localparam logic [STATUS_W-1:0] STATUS_TOO_FEW    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CONTROLLED = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_OWN_ID       = 3'd0;
	localparam logic [2:0] REG_TARGET_RANGE = 3'd1;
	localparam logic [2:0] REG_RANGE_P_GAIN = 3'd2;
	localparam logic [2:0] REG_RANGE_D_GAIN = 3'd3;
	localparam logic [2:0] REG_ANGLE_P_GAIN = 3'd4;
	localparam logic [2:0] REG_ANGLE_D_GAIN = 3'd5;

	// Controller constants. The bearing setpoint is pi/2 in Q3.12.
	localparam logic signed [15:0] HALF_PI_Q12 = 16'sd6434;
	localparam logic signed [20:0] BASE_SPEED  = 21'sd200;
	localparam logic signed [35:0] BASE_SCALED = 36'sd819200;
	localparam logic signed [35:0] FRAC_ROUND  = 36'sd4095;
	localparam logic signed [23:0] SPEED_MAX   = 24'sd1000;
	localparam logic signed [23:0] SPEED_MIN   = -24'sd1000;

	// floor(2^32 / 25): the range term is divided by 200 as a shift by 3
	// followed by a reciprocal multiply by 1/25 and one correction step.
	localparam logic [27:0] RECIP_25 = 28'd171798691;
	localparam logic [22:0] DIV_25   = 23'd25;

	typedef struct packed {
		logic [15:0] own_id;
		logic [15:0] target_range;
		logic [7:0]  range_p_gain;
		logic [7:0]  range_d_gain;
		logic [7:0]  angle_p_gain;
		logic [7:0]  angle_d_gain;
	} cfg_t;

endpackage

[rtl/median_bearing_pd_wall_follower.sv]
// Channel  | Direction | Beat contents
// ---------+-----------+------------------------------------------------------
// s_*      | in        | one polling attempt: received flag, range, bearing, id
// m_*      | out       | one wheel command pair and round status per round
// APB      | in        | six configuration registers at byte addresses 0..20
//
// The front end takes one beat per cycle whenever the round queue has room.
// A controlled round runs the rank sweep, pick sweep and controller steps;
// an id mismatch skips the controller steps, a too-few round skips all three.
// arst_n clears the counters, the queue, the previous errors and the result valid.
// A waiting result stalls the back end; the input stalls once the queue is full too.
module median_bearing_pd_wall_follower #(
	parameter int SAMPLES       = 5,
	parameter int ATTEMPT_LIMIT = 300
) (
	input  logic        clk,
	input  logic        arst_n,

	// Polling attempts.
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] sample_range, [30:16] sample_bearing, [46:31] sender_id, [47] pad
	input  logic [47:0] s_tdata,
	// [0] received
	input  logic        s_tuser,

	// Round results.
	output logic        m_tvalid,
	input  logic        m_tready,
	// [10:0] left_speed, [21:11] right_speed, [23:22] pad
	output logic [23:0] m_tdata,
	// [1:0] round_status
	output logic [1:0]  m_tuser,

	// Configuration.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int JOB_W = CNT_W + 1 + SAMPLES * mbwf_pkg::SAMPLE_BITS;

	mbwf_pkg::cfg_t cfg_q;

	logic             cfg_wr;
	logic             push;
	logic             q_full;
	logic             q_empty;
	logic             q_pop;
	logic [JOB_W-1:0] push_data;
	logic [JOB_W-1:0] head_data;

	logic signed [mbwf_pkg::SPEED_W-1:0] left_speed;
	logic signed [mbwf_pkg::SPEED_W-1:0] right_speed;
	logic [mbwf_pkg::STATUS_W-1:0]       round_status;

	// Registers are written on the access phase of an APB write; the
	// register index is the word address, and unknown indexes are dropped.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_id       <= 16'd2;
			cfg_q.target_range <= 16'd1000;
			cfg_q.range_p_gain <= 8'd20;
			cfg_q.range_d_gain <= 8'd0;
			cfg_q.angle_p_gain <= 8'd10;
			cfg_q.angle_d_gain <= 8'd3;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				mbwf_pkg::REG_OWN_ID:       cfg_q.own_id       <= pwdata[15:0];
				mbwf_pkg::REG_TARGET_RANGE: cfg_q.target_range <= pwdata[15:0];
				mbwf_pkg::REG_RANGE_P_GAIN: cfg_q.range_p_gain <= pwdata[7:0];
				mbwf_pkg::REG_RANGE_D_GAIN: cfg_q.range_d_gain <= pwdata[7:0];
				mbwf_pkg::REG_ANGLE_P_GAIN: cfg_q.angle_p_gain <= pwdata[7:0];
				mbwf_pkg::REG_ANGLE_D_GAIN: cfg_q.angle_d_gain <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			mbwf_pkg::REG_OWN_ID:       prdata = {16'd0, cfg_q.own_id};
			mbwf_pkg::REG_TARGET_RANGE: prdata = {16'd0, cfg_q.target_range};
			mbwf_pkg::REG_RANGE_P_GAIN: prdata = {24'd0, cfg_q.range_p_gain};
			mbwf_pkg::REG_RANGE_D_GAIN: prdata = {24'd0, cfg_q.range_d_gain};
			mbwf_pkg::REG_ANGLE_P_GAIN: prdata = {24'd0, cfg_q.angle_p_gain};
			mbwf_pkg::REG_ANGLE_D_GAIN: prdata = {24'd0, cfg_q.angle_d_gain};
			default:                    prdata = 32'd0;
		endcase
	end

	// Front end: counts attempts and samples and closes each round.
	mbwf_front #(
		.SAMPLES      (SAMPLES),
		.ATTEMPT_LIMIT(ATTEMPT_LIMIT),
		.CNT_W        (CNT_W),
		.JOB_W        (JOB_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.received      (s_tuser),
		.sample_range  (s_tdata[15:0]),
		.sample_bearing(s_tdata[30:16]),
		.sender_id     (s_tdata[46:31]),
		.push          (push),
		.job_data      (push_data),
		.q_full        (q_full)
	);

	// Closed rounds wait here with their samples.
	mbwf_queue #(
		.W(JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (q_pop),
		.head_data(head_data),
		.empty    (q_empty)
	);

	// Back end: median by stable rank, id check, PD controller, output register.
	mbwf_back #(
		.SAMPLES(SAMPLES),
		.CNT_W  (CNT_W),
		.JOB_W  (JOB_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.job_data    (head_data),
		.cfg         (cfg_q),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.left_speed  (left_speed),
		.right_speed (right_speed),
		.round_status(round_status)
	);

	assign m_tdata = {2'b00, right_speed, left_speed};
	assign m_tuser = round_status;

endmodule

[rtl/mbwf_queue.sv]
module mbwf_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] head_data,
	output logic         empty
);

	logic [W-1:0] entry_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   used_q;
	logic         do_push;
	logic         do_pop;

	assign full      = (used_q == 2'd2);
	assign empty     = (used_q == 2'd0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			used_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10:   used_q <= used_q + 2'd1;
				2'b01:   used_q <= used_q - 2'd1;
				default: used_q <= used_q;
			endcase
		end
	end

endmodule

[rtl/mbwf_front.sv]
module mbwf_front #(
	parameter int SAMPLES       = 5,
	parameter int ATTEMPT_LIMIT = 300,
	parameter int CNT_W         = $clog2(SAMPLES + 1),
	parameter int JOB_W         = CNT_W + 1 + SAMPLES * mbwf_pkg::SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                received,
	input  logic [mbwf_pkg::RANGE_W-1:0]        sample_range,
	input  logic signed [mbwf_pkg::BEARING_W-1:0] sample_bearing,
	input  logic [mbwf_pkg::ID_W-1:0]           sender_id,
	output logic                                push,
	output logic [JOB_W-1:0]                    job_data,
	input  logic                                q_full
);

	localparam int ACNT_W = $clog2(ATTEMPT_LIMIT + 1);
	localparam int IDX_W  = $clog2(SAMPLES);
	localparam int R_OFS  = CNT_W + 1;
	localparam int B_OFS  = R_OFS + SAMPLES * mbwf_pkg::RANGE_W;
	localparam int I_OFS  = B_OFS + SAMPLES * mbwf_pkg::BEARING_W;
	localparam logic [CNT_W-1:0]  SAMPLES_C = CNT_W'(SAMPLES);
	localparam logic [CNT_W-1:0]  HALF_C    = CNT_W'(SAMPLES / 2);
	localparam logic [ACNT_W-1:0] LIMIT_C   = ACNT_W'(ATTEMPT_LIMIT);

	logic [mbwf_pkg::RANGE_W-1:0]   ranges_q   [SAMPLES];
	logic [mbwf_pkg::BEARING_W-1:0] bearings_q [SAMPLES];
	logic [mbwf_pkg::ID_W-1:0]      ids_q      [SAMPLES];
	logic [CNT_W-1:0]               cnt_q;
	logic [ACNT_W-1:0]              att_q;

	logic              take;
	logic              accept;
	logic              done;
	logic [CNT_W-1:0]  cnt_nxt;
	logic [ACNT_W-1:0] att_nxt;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign take     = received && (cnt_q < SAMPLES_C);
	assign cnt_nxt  = cnt_q + CNT_W'(take);
	assign att_nxt  = att_q + ACNT_W'(1);
	assign done     = (cnt_nxt == SAMPLES_C) || (att_nxt >= LIMIT_C);
	assign push     = accept && done;

	// The round handed to the back end already holds the sample of the
	// closing beat, merged at its slot.
	always_comb begin
		logic here;
		job_data = '0;
		job_data[CNT_W-1:0] = cnt_nxt;
		job_data[CNT_W]     = (cnt_nxt < HALF_C);
		for (int k = 0; k < SAMPLES; k++) begin
			here = take && (cnt_q == CNT_W'(k));
			job_data[R_OFS + k * mbwf_pkg::RANGE_W +: mbwf_pkg::RANGE_W] =
				here ? sample_range : ranges_q[k];
			job_data[B_OFS + k * mbwf_pkg::BEARING_W +: mbwf_pkg::BEARING_W] =
				here ? sample_bearing : bearings_q[k];
			job_data[I_OFS + k * mbwf_pkg::ID_W +: mbwf_pkg::ID_W] =
				here ? sender_id : ids_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && take) begin
			ranges_q[cnt_q[IDX_W-1:0]]   <= sample_range;
			bearings_q[cnt_q[IDX_W-1:0]] <= sample_bearing;
			ids_q[cnt_q[IDX_W-1:0]]      <= sender_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			att_q <= '0;
		end else if (accept) begin
			if (done) begin
				cnt_q <= '0;
				att_q <= '0;
			end else begin
				cnt_q <= cnt_nxt;
				att_q <= att_nxt;
			end
		end
	end

endmodule

[rtl/mbwf_back.sv]
module mbwf_back #(
	parameter int SAMPLES = 5,
	parameter int CNT_W   = $clog2(SAMPLES + 1),
	parameter int JOB_W   = CNT_W + 1 + SAMPLES * mbwf_pkg::SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  logic [JOB_W-1:0]                     job_data,
	input  mbwf_pkg::cfg_t                       cfg,
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output logic signed [mbwf_pkg::SPEED_W-1:0]  left_speed,
	output logic signed [mbwf_pkg::SPEED_W-1:0]  right_speed,
	output logic [mbwf_pkg::STATUS_W-1:0]        round_status
);

	localparam int IDX_W = $clog2(SAMPLES);
	localparam int R_OFS = CNT_W + 1;
	localparam int B_OFS = R_OFS + SAMPLES * mbwf_pkg::RANGE_W;
	localparam int I_OFS = B_OFS + SAMPLES * mbwf_pkg::BEARING_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_RANK  = 4'd1;
	localparam logic [3:0] ST_PICK  = 4'd2;
	localparam logic [3:0] ST_CHECK = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_SUM   = 4'd5;
	localparam logic [3:0] ST_RECIP = 4'd6;
	localparam logic [3:0] ST_CORR  = 4'd7;
	localparam logic [3:0] ST_SPEED = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	// Truncate toward zero after the Q.12 scaling, then clamp to +-1000.
	function automatic logic signed [mbwf_pkg::SPEED_W-1:0] to_speed(
		input logic signed [35:0] x
	);
		logic signed [35:0] t;
		logic signed [23:0] s;
		t = x[35] ? ((x + mbwf_pkg::FRAC_ROUND) >>> 12) : (x >>> 12);
		s = t[23:0];
		if (s > mbwf_pkg::SPEED_MAX) begin
			s = mbwf_pkg::SPEED_MAX;
		end else if (s < mbwf_pkg::SPEED_MIN) begin
			s = mbwf_pkg::SPEED_MIN;
		end
		return s[mbwf_pkg::SPEED_W-1:0];
	endfunction

	logic [3:0] state_q;

	// Working copy of the round being processed.
	logic [mbwf_pkg::RANGE_W-1:0]   r_q [SAMPLES];
	logic [mbwf_pkg::BEARING_W-1:0] b_q [SAMPLES];
	logic [mbwf_pkg::ID_W-1:0]      id_q [SAMPLES];
	logic [CNT_W-1:0]               rank_q [SAMPLES];
	logic [CNT_W-1:0]               n_q;
	logic [IDX_W-1:0]               j_q;

	logic [mbwf_pkg::RANGE_W-1:0]          med_r_q;
	logic signed [mbwf_pkg::BEARING_W-1:0] med_b_q;
	logic [mbwf_pkg::ID_W-1:0]             med_id_q;

	logic signed [16:0] er_q;
	logic signed [15:0] ea_q;
	logic signed [17:0] der_q;
	logic signed [16:0] dea_q;
	logic signed [25:0] prp_q;
	logic signed [26:0] prd_q;
	logic signed [24:0] pap_q;
	logic signed [25:0] pad_q;
	logic signed [27:0] ur_q;
	logic signed [26:0] ua_q;
	logic               neg_q;
	logic [22:0]        bq_q;
	logic [50:0]        prod_q;
	logic [18:0]        qa_q;
	logic signed [35:0] xo_q;
	logic signed [35:0] xi_q;
	logic [mbwf_pkg::STATUS_W-1:0] stat_q;

	logic signed [16:0] prev_r_q;
	logic signed [15:0] prev_a_q;

	logic signed [mbwf_pkg::SPEED_W-1:0] left_q;
	logic signed [mbwf_pkg::SPEED_W-1:0] right_q;
	logic [mbwf_pkg::STATUS_W-1:0]       res_stat_q;
	logic                                res_valid_q;

	logic               out_free;
	logic               emit_go;
	logic               too_few;
	logic [IDX_W-1:0]   last_j;
	logic [CNT_W-1:0]   cnt_m1;
	logic [mbwf_pkg::RANGE_W-1:0] r_j;
	logic signed [16:0] er_c;
	logic signed [15:0] ea_c;
	logic signed [17:0] der_c;
	logic signed [16:0] dea_c;
	logic [27:0]        ur_abs_c;
	logic [22:0]        b_c;
	logic [18:0]        q0_c;
	logic [22:0]        q25_c;
	logic [22:0]        rem_c;
	logic signed [20:0] sq_c;
	logic signed [20:0] diff_o_c;
	logic signed [20:0] diff_i_c;
	logic signed [32:0] ua_x_c;
	logic signed [32:0] turn_c;
	logic signed [35:0] turn_x_c;
	logic signed [35:0] do_x_c;
	logic signed [35:0] di_x_c;

	assign out_free     = !res_valid_q || res_ready;
	assign emit_go      = (state_q == ST_EMIT) && out_free;
	assign q_pop        = (state_q == ST_IDLE) && !q_empty;
	assign too_few      = job_data[CNT_W];
	assign cnt_m1       = n_q - CNT_W'(1);
	assign last_j       = cnt_m1[IDX_W-1:0];
	assign r_j          = r_q[j_q];
	assign res_valid    = res_valid_q;
	assign left_speed   = left_q;
	assign right_speed  = right_q;
	assign round_status = res_stat_q;

	always_comb begin
		er_c  = $signed({1'b0, med_r_q}) - $signed({1'b0, cfg.target_range});
		ea_c  = $signed({med_b_q[mbwf_pkg::BEARING_W-1], med_b_q}) - mbwf_pkg::HALF_PI_Q12;
		der_c = $signed({er_c[16], er_c}) - $signed({prev_r_q[16], prev_r_q});
		dea_c = $signed({ea_c[15], ea_c}) - $signed({prev_a_q[15], prev_a_q});

		ur_abs_c = ur_q[27] ? 28'(-ur_q) : 28'(ur_q);
		b_c      = ur_abs_c[25:3];

		q0_c  = prod_q[50:32];
		q25_c = 23'({q0_c, 4'b0000}) + 23'({q0_c, 3'b000}) + 23'(q0_c);
		rem_c = bq_q - q25_c;

		sq_c     = neg_q ? -$signed({2'b00, qa_q}) : $signed({2'b00, qa_q});
		diff_o_c = mbwf_pkg::BASE_SPEED - sq_c;
		diff_i_c = mbwf_pkg::BASE_SPEED + sq_c;
		ua_x_c   = {{6{ua_q[26]}}, ua_q};
		turn_c   = (ua_x_c <<< 5) - (ua_x_c <<< 1);
		turn_x_c = {{3{turn_c[32]}}, turn_c};
		do_x_c   = {{15{diff_o_c[20]}}, diff_o_c};
		di_x_c   = {{15{diff_i_c[20]}}, diff_i_c};
	end

	// Datapath registers, no reset needed.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q <= job_data[CNT_W-1:0];
				for (int k = 0; k < SAMPLES; k++) begin
					r_q[k]  <= job_data[R_OFS + k * mbwf_pkg::RANGE_W +: mbwf_pkg::RANGE_W];
					b_q[k]  <= job_data[B_OFS + k * mbwf_pkg::BEARING_W +: mbwf_pkg::BEARING_W];
					id_q[k] <= job_data[I_OFS + k * mbwf_pkg::ID_W +: mbwf_pkg::ID_W];
					rank_q[k] <= '0;
				end
				stat_q <= mbwf_pkg::STATUS_TOO_FEW;
				xo_q   <= mbwf_pkg::BASE_SCALED;
				xi_q   <= mbwf_pkg::BASE_SCALED;
			end
			ST_RANK: begin
				// Stable rank: earlier equal ranges count as smaller.
				for (int k = 0; k < SAMPLES; k++) begin
					if ((r_j < r_q[k]) || ((r_j == r_q[k]) && (j_q < IDX_W'(k)))) begin
						rank_q[k] <= rank_q[k] + CNT_W'(1);
					end
				end
			end
			ST_PICK: begin
				if (rank_q[j_q] == (n_q >> 1)) begin
					med_r_q  <= r_q[j_q];
					med_b_q  <= b_q[j_q];
					med_id_q <= id_q[j_q];
				end
			end
			ST_CHECK: begin
				stat_q <= (med_id_q == cfg.own_id) ? mbwf_pkg::STATUS_CONTROLLED
				                                   : mbwf_pkg::STATUS_MISMATCH;
				er_q  <= er_c;
				ea_q  <= ea_c;
				der_q <= der_c;
				dea_q <= dea_c;
			end
			ST_MUL: begin
				prp_q <= $signed({1'b0, cfg.range_p_gain}) * er_q;
				prd_q <= $signed({1'b0, cfg.range_d_gain}) * der_q;
				pap_q <= $signed({1'b0, cfg.angle_p_gain}) * ea_q;
				pad_q <= $signed({1'b0, cfg.angle_d_gain}) * dea_q;
			end
			ST_SUM: begin
				ur_q <= 28'(prp_q) + 28'(prd_q);
				ua_q <= 27'(pap_q) + 27'(pad_q);
			end
			ST_RECIP: begin
				neg_q  <= ur_q[27];
				bq_q   <= b_c;
				prod_q <= 51'(b_c) * 51'(mbwf_pkg::RECIP_25);
			end
			ST_CORR: begin
				qa_q <= (rem_c >= mbwf_pkg::DIV_25) ? q0_c + 19'd1 : q0_c;
			end
			ST_SPEED: begin
				xo_q <= (do_x_c <<< 12) + turn_x_c;
				xi_q <= (di_x_c <<< 12) - turn_x_c;
			end
			ST_EMIT: begin
				if (emit_go) begin
					left_q     <= to_speed(xi_q);
					right_q    <= to_speed(xo_q);
					res_stat_q <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			j_q         <= '0;
			prev_r_q    <= '0;
			prev_a_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					j_q <= '0;
					if (!q_empty) begin
						state_q <= too_few ? ST_EMIT : ST_RANK;
					end
				end
				ST_RANK: begin
					if (j_q == last_j) begin
						j_q     <= '0;
						state_q <= ST_PICK;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_PICK: begin
					if (j_q == last_j) begin
						j_q     <= '0;
						state_q <= ST_CHECK;
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				ST_CHECK: begin
					state_q <= (med_id_q == cfg.own_id) ? ST_MUL : ST_EMIT;
				end
				ST_MUL:   state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_RECIP;
				ST_RECIP: state_q <= ST_CORR;
				ST_CORR:  state_q <= ST_SPEED;
				ST_SPEED: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (emit_go) begin
						if (stat_q == mbwf_pkg::STATUS_CONTROLLED) begin
							prev_r_q <= er_q;
							prev_a_q <= ea_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sim/median_bearing_pd_wall_follower_tb.sv]
module median_bearing_pd_wall_follower_tb;

	localparam int SAMPLES       = 5;
	localparam int ATTEMPT_LIMIT = 300;

	// Controller constants, kept here so that the expected commands are worked
	// out independently of the design.
	localparam int CRUISE_SPEED     = 200;
	localparam int TURN_GAIN        = 30;
	localparam int RANGE_DIVISOR    = 200;
	localparam int HEADING_SETPOINT = 6434;
	localparam int FRAC_ONE         = 4096;
	localparam int WHEEL_LIMIT      = 1000;
	localparam int BEARING_LIMIT    = 12868;

	// Register indexes that decode to nothing in the block.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// Give the back end ample room to finish a round before touching the
	// registers or ending the run.
	localparam int SETTLE_CYCLES  = 4 * (2 * SAMPLES + 8);
	// The longest legal stretch with no beat anywhere is the long receiver
	// hold-off of the back-pressure test.
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5 * HOLD_CYCLES;

	// One polling attempt as the sender sees it.
	typedef struct {
		logic                                  heard;
		logic [mbwf_pkg::RANGE_W-1:0]          range_val;
		logic signed [mbwf_pkg::BEARING_W-1:0] bearing;
		logic [mbwf_pkg::ID_W-1:0]             sender;
	} poll_t;

	// One wheel command pair with the round outcome.
	typedef struct {
		logic signed [mbwf_pkg::SPEED_W-1:0] left;
		logic signed [mbwf_pkg::SPEED_W-1:0] right;
		logic [mbwf_pkg::STATUS_W-1:0]       status;
	} wheel_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [15:0] sample_range, [30:16] sample_bearing, [46:31] sender_id, [47] pad
	logic [47:0] s_tdata;
	// [0] received
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// [10:0] left_speed, [21:11] right_speed, [23:22] pad
	logic [23:0] m_tdata;
	// [1:0] round_status
	logic [1:0]  m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	median_bearing_pd_wall_follower #(
		.SAMPLES      (SAMPLES),
		.ATTEMPT_LIMIT(ATTEMPT_LIMIT)
	) DUT (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the register file and of the round state. The shadow changes
	// at the moment a write or a polling beat is accepted, which matches the
	// block as long as writes only happen while its back end is idle.
	mbwf_pkg::cfg_t                        shadow_cfg;
	logic [mbwf_pkg::RANGE_W-1:0]          held_range   [SAMPLES];
	logic signed [mbwf_pkg::BEARING_W-1:0] held_bearing [SAMPLES];
	logic [mbwf_pkg::ID_W-1:0]             held_sender  [SAMPLES];
	int                                    held_count;
	int                                    attempts_in_round;
	longint                                last_range_err;
	longint                                last_bearing_err;

	// Wheel commands predicted but not yet seen on the result side.
	wheel_cmd_t pending_cmds [$];

	int fault_count;
	int attempts_sent;
	int idle_max_send;
	int idle_max_recv;
	int hold_request;
	int stall_left;
	int quiet_cycles;

	function automatic logic signed [mbwf_pkg::SPEED_W-1:0] clamp_wheel(input longint v);
		logic signed [mbwf_pkg::SPEED_W-1:0] w;
		if (v > WHEEL_LIMIT) begin
			w = mbwf_pkg::SPEED_W'(WHEEL_LIMIT);
		end else if (v < -WHEEL_LIMIT) begin
			w = mbwf_pkg::SPEED_W'(-WHEEL_LIMIT);
		end else begin
			w = mbwf_pkg::SPEED_W'(v);
		end
		return w;
	endfunction

	// Closes a round: with enough samples, picks the median sample by range (ties
	// stay in arrival order) and runs the PD step when the median came from our own id.
	function automatic wheel_cmd_t steer_from_median();
		int         order [SAMPLES];
		int         i;
		int         j;
		int         key;
		int         mid;
		longint     e_range;
		longint     e_bearing;
		longint     u_range;
		longint     u_bearing;
		longint     q;
		longint     outside;
		longint     inner;
		wheel_cmd_t cmd;
		cmd.left   = mbwf_pkg::SPEED_W'(CRUISE_SPEED);
		cmd.right  = mbwf_pkg::SPEED_W'(CRUISE_SPEED);
		if (held_count < SAMPLES / 2) begin
			cmd.status = mbwf_pkg::STATUS_TOO_FEW;
			return cmd;
		end
		for (i = 0; i < held_count; i++) order[i] = i;
		for (i = 1; i < held_count; i++) begin
			key = order[i];
			j = i;
			while (j > 0 && held_range[order[j - 1]] > held_range[key]) begin
				order[j] = order[j - 1];
				j--;
			end
			order[j] = key;
		end
		mid = order[held_count / 2];
		if (held_sender[mid] != shadow_cfg.own_id) begin
			cmd.status = mbwf_pkg::STATUS_MISMATCH;
			return cmd;
		end
		e_range   = longint'(held_range[mid]) - longint'(shadow_cfg.target_range);
		e_bearing = longint'(held_bearing[mid]) - HEADING_SETPOINT;
		u_range   = longint'(shadow_cfg.range_p_gain) * e_range
			+ longint'(shadow_cfg.range_d_gain) * (e_range - last_range_err);
		u_bearing = longint'(shadow_cfg.angle_p_gain) * e_bearing
			+ longint'(shadow_cfg.angle_d_gain) * (e_bearing - last_bearing_err);
		// Signed division truncates toward zero, as the controller does.
		q       = u_range / RANGE_DIVISOR;
		outside = ((CRUISE_SPEED - q) * FRAC_ONE + TURN_GAIN * u_bearing) / FRAC_ONE;
		inner   = ((CRUISE_SPEED + q) * FRAC_ONE - TURN_GAIN * u_bearing) / FRAC_ONE;
		last_range_err   = e_range;
		last_bearing_err = e_bearing;
		cmd.left   = clamp_wheel(inner);
		cmd.right  = clamp_wheel(outside);
		cmd.status = mbwf_pkg::STATUS_CONTROLLED;
		return cmd;
	endfunction

	// Books one accepted polling beat and queues a command when it ends a round.
	function automatic void track_attempt(input poll_t p);
		attempts_in_round++;
		if (p.heard && held_count < SAMPLES) begin
			held_range[held_count]   = p.range_val;
			held_bearing[held_count] = p.bearing;
			held_sender[held_count]  = p.sender;
			held_count++;
		end
		if (held_count >= SAMPLES || attempts_in_round >= ATTEMPT_LIMIT) begin
			pending_cmds.push_back(steer_from_median());
			held_count        = 0;
			attempts_in_round = 0;
		end
	endfunction

	function automatic poll_t heard_sample(input logic [mbwf_pkg::RANGE_W-1:0] r,
			input int b, input logic [mbwf_pkg::ID_W-1:0] id);
		poll_t p;
		p.heard     = 1'b1;
		p.range_val = r;
		p.bearing   = mbwf_pkg::BEARING_W'(b);
		p.sender    = id;
		return p;
	endfunction

	// Random attempt. Ranges lean toward a few tiny values (so that ties are
	// common) and toward the setpoint; ids lean toward our own id so that the
	// controlled path is taken often.
	function automatic poll_t make_poll(input logic heard);
		poll_t p;
		int    pick;
		p.heard = heard;
		pick = $urandom_range(0, 3);
		case (pick)
			0: p.range_val = mbwf_pkg::RANGE_W'($urandom_range(0, 3));
			1: p.range_val = mbwf_pkg::RANGE_W'(shadow_cfg.target_range
				+ $urandom_range(0, 400) - 200);
			default: p.range_val = mbwf_pkg::RANGE_W'($urandom_range(0, 65535));
		endcase
		pick = $urandom_range(0, 9);
		if (pick == 0) begin
			p.bearing = mbwf_pkg::BEARING_W'(-BEARING_LIMIT);
		end else if (pick == 1) begin
			p.bearing = mbwf_pkg::BEARING_W'(BEARING_LIMIT);
		end else begin
			p.bearing = mbwf_pkg::BEARING_W'(
				int'($urandom_range(0, 2 * BEARING_LIMIT)) - BEARING_LIMIT);
		end
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			p.sender = shadow_cfg.own_id;
		end else if (pick < 8) begin
			p.sender = shadow_cfg.own_id ^ (16'd1 << $urandom_range(0, 15));
		end else begin
			p.sender = mbwf_pkg::ID_W'($urandom);
		end
		return p;
	endfunction

	// Offers one polling beat after a random gap and holds it until taken.
	// When the gap is zero, tvalid simply stays high from the previous beat.
	task automatic send_attempt(input poll_t p);
		int gap;
		gap = $urandom_range(0, idle_max_send);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, p.sender, p.bearing, p.range_val};
		s_tuser  <= p.heard;
		do @(posedge clk); while (s_tready !== 1'b1);
		track_attempt(p);
		attempts_sent++;
	endtask

	// Stops offering beats, waits for every predicted command and then lets
	// the back end settle, so that the block is idle afterwards.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge that ends the access cycle.
	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			mbwf_pkg::REG_OWN_ID:       shadow_cfg.own_id       = value[15:0];
			mbwf_pkg::REG_TARGET_RANGE: shadow_cfg.target_range = value[15:0];
			mbwf_pkg::REG_RANGE_P_GAIN: shadow_cfg.range_p_gain = value[7:0];
			mbwf_pkg::REG_RANGE_D_GAIN: shadow_cfg.range_d_gain = value[7:0];
			mbwf_pkg::REG_ANGLE_P_GAIN: shadow_cfg.angle_p_gain = value[7:0];
			mbwf_pkg::REG_ANGLE_D_GAIN: shadow_cfg.angle_d_gain = value[7:0];
			default: ;
		endcase
	endtask

	// Writes all six registers. The unused upper bits of each word carry
	// random junk, which the block must drop.
	task automatic program_controller(input mbwf_pkg::cfg_t c);
		write_register(mbwf_pkg::REG_OWN_ID,       {16'($urandom), c.own_id});
		write_register(mbwf_pkg::REG_TARGET_RANGE, {16'($urandom), c.target_range});
		write_register(mbwf_pkg::REG_RANGE_P_GAIN, {24'($urandom), c.range_p_gain});
		write_register(mbwf_pkg::REG_RANGE_D_GAIN, {24'($urandom), c.range_d_gain});
		write_register(mbwf_pkg::REG_ANGLE_P_GAIN, {24'($urandom), c.angle_p_gain});
		write_register(mbwf_pkg::REG_ANGLE_D_GAIN, {24'($urandom), c.angle_d_gain});
	endtask

	// A well-formed round: SAMPLES receptions, sometimes with silent attempts
	// in between.
	task automatic send_round();
		int i;
		for (i = 0; i < SAMPLES; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) send_attempt(make_poll(1'b0));
			end
			send_attempt(make_poll(1'b1));
		end
	endtask

	// Reset values of the registers; the sorted median of this round comes
	// from our id, and the two equal ranges must keep their arrival order.
	task automatic test_median_selection();
		send_attempt(heard_sample(16'hFFFF, BEARING_LIMIT, 16'hFFFF));
		send_attempt(heard_sample(16'h0000, -BEARING_LIMIT, 16'h0000));
		send_attempt(heard_sample(16'd30000, BEARING_LIMIT, 16'd2));
		send_attempt(heard_sample(16'd30000, -BEARING_LIMIT, 16'd7));
		send_attempt(heard_sample(16'd5, 0, 16'hFFFF));
	endtask

	// All ranges tie, so the median is the middle arrival, which carries a
	// foreign id. The previous errors must survive this round untouched.
	task automatic test_mismatch_on_ties();
		send_attempt(heard_sample(16'd1000, 100, 16'd2));
		send_attempt(heard_sample(16'd1000, 200, 16'd2));
		send_attempt(heard_sample(16'd1000, 300, 16'd9));
		send_attempt(heard_sample(16'd1000, 400, 16'd2));
		send_attempt(heard_sample(16'd1000, 500, 16'd2));
	endtask

	// Full gains and a zero setpoint drive both wheels into saturation.
	task automatic test_saturation();
		mbwf_pkg::cfg_t c;
		c = '{own_id: 16'd2, target_range: 16'd0, range_p_gain: 8'd255,
			range_d_gain: 8'd255, angle_p_gain: 8'd255, angle_d_gain: 8'd255};
		program_controller(c);
		repeat (SAMPLES) send_attempt(heard_sample(16'hFFFF, -BEARING_LIMIT, 16'd2));
	endtask

	// The own id changes while a round is half collected; the median must be
	// judged against the new id.
	task automatic test_midround_write();
		send_attempt(heard_sample(16'd10, 1000, 16'h1234));
		send_attempt(heard_sample(16'd20, 2000, 16'h1234));
		write_register(mbwf_pkg::REG_OWN_ID, 32'h0000_1234);
		send_attempt(heard_sample(16'd30, 3000, 16'h1234));
		send_attempt(heard_sample(16'd40, 4000, 16'h4321));
		send_attempt(heard_sample(16'd50, 5000, 16'h1234));
	endtask

	// Writes to addresses past the last register must change nothing.
	task automatic test_unknown_register();
		write_register(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_register(REG_SPARE_HI, 32'h0000_0000);
		repeat (SAMPLES) send_attempt(make_poll(1'b1));
	endtask

	// Rounds closed by the attempt limit with 0 to SAMPLES-1 receptions, which
	// covers both too-few outcomes and the short medians, plus one round whose
	// last reception lands exactly on the limit.
	task automatic test_attempt_limit();
		logic slot [ATTEMPT_LIMIT];
		int   k;
		int   i;
		int   placed;
		int   pos;
		idle_max_send = 2;
		idle_max_recv = 16;
		for (k = 0; k <= SAMPLES; k++) begin
			for (i = 0; i < ATTEMPT_LIMIT; i++) slot[i] = 1'b0;
			placed = 0;
			if (k == SAMPLES) begin
				slot[ATTEMPT_LIMIT - 1] = 1'b1;
				placed = 1;
			end
			while (placed < k) begin
				pos = $urandom_range(0, ATTEMPT_LIMIT - 2);
				if (!slot[pos]) begin
					slot[pos] = 1'b1;
					placed++;
				end
			end
			for (i = 0; i < ATTEMPT_LIMIT; i++) send_attempt(make_poll(slot[i]));
		end
	endtask

	// The receiver holds off for a long stretch while rounds keep coming at
	// full rate: the round queue fills and the block must stall its input.
	// Afterwards the sender pauses until every command has been seen.
	task automatic test_backpressure();
		idle_max_send = 0;
		idle_max_recv = 0;
		hold_request  = HOLD_CYCLES;
		repeat (8) send_round();
		wait_idle();
	endtask

	// Random rounds over several register sets, the extremes among them, and
	// with idle patterns from back-to-back beats to long gaps on either side.
	task automatic test_random_rounds();
		mbwf_pkg::cfg_t c;
		int             ph;
		int             first;
		for (ph = 0; ph < 8; ph++) begin
			c = '{own_id: 16'($urandom), target_range: 16'($urandom),
				range_p_gain: 8'($urandom), range_d_gain: 8'($urandom),
				angle_p_gain: 8'($urandom), angle_d_gain: 8'($urandom)};
			case (ph)
				0: c = '{own_id: 16'd2, target_range: 16'd1000, range_p_gain: 8'd20,
					range_d_gain: 8'd0, angle_p_gain: 8'd10, angle_d_gain: 8'd3};
				1: c = '{default: '0};
				2: c = '{default: '1};
				3: begin
					c.target_range = 16'd30000;
					c.range_p_gain = 8'd255;
					c.range_d_gain = 8'd0;
					c.angle_p_gain = 8'd0;
					c.angle_d_gain = 8'd255;
				end
				4: begin
					c.target_range = 16'hFFFF;
					c.range_p_gain = 8'd1;
					c.range_d_gain = 8'd255;
					c.angle_p_gain = 8'd255;
					c.angle_d_gain = 8'd0;
				end
				default: ;
			endcase
			program_controller(c);
			case (ph % 4)
				0: begin idle_max_send = 16; idle_max_recv = 16; end
				1: begin idle_max_send = 0;  idle_max_recv = 0;  end
				2: begin idle_max_send = 16; idle_max_recv = 0;  end
				default: begin idle_max_send = 0; idle_max_recv = 16; end
			endcase
			first = attempts_sent;
			while (attempts_sent - first < 25) begin
				// Mostly complete rounds; now and then a burst of silent
				// attempts that stretches the round in progress.
				if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 20)) send_attempt(make_poll(1'b0));
				end else begin
					send_round();
				end
			end
		end
	endtask

	// Result side: each beat is checked against the oldest predicted command.
	always @(posedge clk) begin
		wheel_cmd_t                          want;
		logic signed [mbwf_pkg::SPEED_W-1:0] got_left;
		logic signed [mbwf_pkg::SPEED_W-1:0] got_right;
		if (m_tvalid === 1'b1 && m_tready) begin
			got_left  = m_tdata[10:0];
			got_right = m_tdata[21:11];
			if (pending_cmds.size() == 0) begin
				$error("wheel command beat with no round pending: left %0d right %0d",
					got_left, got_right);
				fault_count++;
			end else begin
				want = pending_cmds.pop_front();
				if (got_left !== want.left) begin
					$error("left_speed: expected %0d, got %0d", want.left, got_left);
					fault_count++;
				end
				if (got_right !== want.right) begin
					$error("right_speed: expected %0d, got %0d", want.right, got_right);
					fault_count++;
				end
				if (m_tuser !== want.status) begin
					$error("round_status: expected %0d, got %0d", want.status, m_tuser);
					fault_count++;
				end
			end
		end
	end

	// Receiver: after each beat it draws a stall length; a hold-off request
	// from a test overrides the draw and is counted down here.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left   = hold_request;
			hold_request = 0;
			m_tready <= 1'b0;
		end else if (m_tready && m_tvalid === 1'b1) begin
			stall_left = $urandom_range(0, idle_max_recv);
			m_tready <= (stall_left == 0);
		end else if (!m_tready) begin
			if (stall_left > 0) stall_left--;
			if (stall_left == 0) m_tready <= 1'b1;
		end
	end

	// Watchdog: any accepted beat or register access counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)
				|| (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		shadow_cfg = '{own_id: 16'd2, target_range: 16'd1000, range_p_gain: 8'd20,
			range_d_gain: 8'd0, angle_p_gain: 8'd10, angle_d_gain: 8'd3};
		held_count        = 0;
		attempts_in_round = 0;
		last_range_err    = 0;
		last_bearing_err  = 0;
		fault_count       = 0;
		attempts_sent     = 0;
		hold_request      = 0;
		stall_left        = 0;
		quiet_cycles      = 0;
		idle_max_send     = 16;
		idle_max_recv     = 16;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		m_tready <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_median_selection();
		test_mismatch_on_ties();
		test_saturation();
		test_midround_write();
		test_unknown_register();
		test_attempt_limit();
		test_backpressure();
		test_random_rounds();

		wait_idle();
		if (fault_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[median_bearing_pd_wall_follower.f]
rtl/mbwf_pkg.sv
rtl/mbwf_queue.sv
rtl/mbwf_front.sv
rtl/mbwf_back.sv
rtl/median_bearing_pd_wall_follower.sv
sim/median_bearing_pd_wall_follower_tb.sv
